// ===== rtl/lcci_pkg.sv =====
// Shared types and constants for the line clip and color interpolation block.
// Used by every module in rtl/; depends on nothing else.
package lcci_pkg;

    localparam int COORD_W   = 32;
    localparam int DIFF_W    = 33;
    localparam int EXT_W     = 34;
    localparam int CHAN_W    = 16;
    localparam int COLOR_W   = 48;
    localparam int NUM_AXES  = 3;
    localparam int NUM_CHAN  = 3;
    localparam int NUM_TESTS = 6;
    localparam int REM_W     = 35;
    localparam int IN_W      = 288;
    localparam int OUT_W     = 288;

    // One input segment; start_x sits in the lowest bits.
    typedef struct packed {
        logic [COLOR_W-1:0]        end_color;
        logic [COLOR_W-1:0]        start_color;
        logic signed [COORD_W-1:0] end_z;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_x;
    } lcci_item_t;

    // One clipped segment; visible sits in the lowest bit.
    typedef struct packed {
        logic [COLOR_W-1:0]        out_end_color;
        logic [COLOR_W-1:0]        out_start_color;
        logic signed [COORD_W-1:0] out_end_z;
        logic signed [COORD_W-1:0] out_end_y;
        logic signed [COORD_W-1:0] out_end_x;
        logic signed [COORD_W-1:0] out_start_z;
        logic signed [COORD_W-1:0] out_start_y;
        logic signed [COORD_W-1:0] out_start_x;
        logic                      visible;
    } lcci_result_t;

    // Sign information of one boundary test.
    typedef struct packed {
        logic dpos;
        logic dzero;
        logic npos;
    } lcci_flags_t;

    // One boundary test inside the divider chain.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] dvs;
        logic             neg;
        logic             ovf;
        lcci_flags_t      flags;
    } lcci_lane_t;

endpackage

// ===== rtl/line_clip_color_interp.sv =====
// Top level: clips a 3D segment to the cube -1..+1 per axis and interpolates colors.
// Depends on lcci_pkg, lcci_div_cell, lcci_clip_cell and lcci_interp.
//
//   Channel   Direction  Handshake            Payload
//   s_*       in         s_tvalid / s_tready  s_tdata: one segment, 288 bits
//   m_*       out        m_tvalid / m_tready  m_tdata: one clipped segment, 288 bits;
//                                             m_tuser: visible
//
// One segment enters per cycle while s_tready is high. A result passes through
// one setup stage, PARAM_FRAC_BITS + 1 divider cells, one parameter stage,
// six clip cells, a multiply stage and the output register.
// Reset clears only the valid bits of the stages. When the output register holds
// a result that is not taken, every stage holds and s_tready is low.
module line_clip_color_interp #(
    parameter int COORD_FRAC_BITS = 16,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, start_color, end_color
    input  logic [lcci_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // out_start_x, out_start_y, out_start_z, out_end_x, out_end_y, out_end_z,
    // out_start_color, out_end_color
    output logic [lcci_pkg::OUT_W-1:0]  m_tdata,
    // visible
    output logic [0:0]                  m_tuser
);

    localparam int NT = lcci_pkg::NUM_TESTS;
    localparam int NC = PARAM_FRAC_BITS + 1;
    localparam int QW = PARAM_FRAC_BITS + 1;
    localparam int TW = PARAM_FRAC_BITS + 2;
    localparam logic signed [lcci_pkg::EXT_W-1:0] C_ONE =
        lcci_pkg::EXT_W'(64'd1 << COORD_FRAC_BITS);
    localparam logic [QW-1:0] T_SAT = QW'((64'd1 << PARAM_FRAC_BITS) + 64'd1);
    localparam logic [PARAM_FRAC_BITS:0] P_ONE = (PARAM_FRAC_BITS+1)'(64'd1 << PARAM_FRAC_BITS);

    logic                 en;
    lcci_pkg::lcci_item_t in_item;

    // Setup stage.
    logic signed [lcci_pkg::EXT_W-1:0]        s_ext [lcci_pkg::NUM_AXES];
    logic signed [lcci_pkg::EXT_W-1:0]        e_ext [lcci_pkg::NUM_AXES];
    logic signed [lcci_pkg::EXT_W-1:0]        num_w [NT];
    logic signed [lcci_pkg::EXT_W-1:0]        den_w [NT];
    logic [lcci_pkg::DIFF_W-1:0]              num_abs [NT];
    logic [lcci_pkg::DIFF_W-1:0]              den_abs [NT];
    lcci_pkg::lcci_lane_t [NT-1:0]            lane_next;
    lcci_pkg::lcci_lane_t [NT-1:0]            lane_reg;
    lcci_pkg::lcci_item_t                     setup_item_reg;
    logic                                     setup_valid_reg;

    // Divider chain.
    logic                          dv_valid [NC+1];
    lcci_pkg::lcci_item_t          dv_item  [NC+1];
    lcci_pkg::lcci_lane_t [NT-1:0] dv_lane  [NC+1];
    logic [NT-1:0][QW-1:0]         dv_q     [NC+1];

    // Parameter stage.
    logic [QW-1:0]                   tmag [NT];
    logic [NT-1:0][TW-1:0]           t_next;
    logic [NT-1:0][TW-1:0]           t_reg;
    lcci_pkg::lcci_flags_t [NT-1:0]  flags_next;
    lcci_pkg::lcci_flags_t [NT-1:0]  flags_reg;
    lcci_pkg::lcci_item_t            tp_item_reg;
    logic                            tp_valid_reg;

    // Clip chain.
    logic                            cl_valid [NT+1];
    lcci_pkg::lcci_item_t            cl_item  [NT+1];
    logic                            cl_keep  [NT+1];
    logic [PARAM_FRAC_BITS:0]        cl_te    [NT+1];
    logic [PARAM_FRAC_BITS:0]        cl_tl    [NT+1];
    logic [NT-1:0][TW-1:0]           cl_t     [NT+1];
    lcci_pkg::lcci_flags_t [NT-1:0]  cl_flags [NT+1];

    lcci_pkg::lcci_result_t          result;

    // Every stage moves together unless a finished result is waiting.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign in_item  = lcci_pkg::lcci_item_t'(s_tdata);

    // Numerators and denominators of the six boundary tests, with their signs.
    always_comb
    begin
        s_ext[0] = lcci_pkg::EXT_W'(in_item.start_x);
        s_ext[1] = lcci_pkg::EXT_W'(in_item.start_y);
        s_ext[2] = lcci_pkg::EXT_W'(in_item.start_z);
        e_ext[0] = lcci_pkg::EXT_W'(in_item.end_x);
        e_ext[1] = lcci_pkg::EXT_W'(in_item.end_y);
        e_ext[2] = lcci_pkg::EXT_W'(in_item.end_z);
        for (int a = 0; a < lcci_pkg::NUM_AXES; a++)
        begin
            den_w[2*a]   = e_ext[a] - s_ext[a];
            num_w[2*a]   = -C_ONE - s_ext[a];
            den_w[2*a+1] = s_ext[a] - e_ext[a];
            num_w[2*a+1] = s_ext[a] - C_ONE;
        end
        for (int k = 0; k < NT; k++)
        begin
            num_abs[k] = num_w[k][lcci_pkg::EXT_W-1] ? lcci_pkg::DIFF_W'(-num_w[k])
                                                      : lcci_pkg::DIFF_W'(num_w[k]);
            den_abs[k] = den_w[k][lcci_pkg::EXT_W-1] ? lcci_pkg::DIFF_W'(-den_w[k])
                                                      : lcci_pkg::DIFF_W'(den_w[k]);
            lane_next[k].rem         = {2'b00, num_abs[k]};
            lane_next[k].dvs         = {2'b00, den_abs[k]};
            lane_next[k].neg         = num_w[k][lcci_pkg::EXT_W-1] ^ den_w[k][lcci_pkg::EXT_W-1];
            lane_next[k].ovf         = {2'b00, num_abs[k]} >= {1'b0, den_abs[k], 1'b0};
            lane_next[k].flags.dzero = den_w[k] == '0;
            lane_next[k].flags.dpos  = !den_w[k][lcci_pkg::EXT_W-1] && (den_w[k] != '0);
            lane_next[k].flags.npos  = !num_w[k][lcci_pkg::EXT_W-1] && (num_w[k] != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            setup_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            setup_item_reg <= in_item;
            lane_reg       <= lane_next;
        end
    end

    // Quotient bits, most significant first, one cell per bit.
    assign dv_valid[0] = setup_valid_reg;
    assign dv_item[0]  = setup_item_reg;
    assign dv_lane[0]  = lane_reg;
    assign dv_q[0]     = '0;

    for (genvar g = 0; g < NC; g++)
    begin : g_div
        lcci_div_cell #(
            .QW(QW)
        ) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (dv_valid[g]),
            .in_item  (dv_item[g]),
            .in_lane  (dv_lane[g]),
            .in_q     (dv_q[g]),
            .out_valid(dv_valid[g+1]),
            .out_item (dv_item[g+1]),
            .out_lane (dv_lane[g+1]),
            .out_q    (dv_q[g+1])
        );
    end

    // Saturate the quotient just above one and apply the sign.
    always_comb
    begin
        for (int k = 0; k < NT; k++)
        begin
            tmag[k]       = (dv_lane[NC][k].ovf || (dv_q[NC][k] > T_SAT)) ? T_SAT : dv_q[NC][k];
            t_next[k]     = dv_lane[NC][k].neg ? -{1'b0, tmag[k]} : {1'b0, tmag[k]};
            flags_next[k] = dv_lane[NC][k].flags;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            tp_valid_reg <= dv_valid[NC];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tp_item_reg <= dv_item[NC];
            t_reg       <= t_next;
            flags_reg   <= flags_next;
        end
    end

    // Tests in order x low boundary, x high boundary, then y and z likewise.
    assign cl_valid[0] = tp_valid_reg;
    assign cl_item[0]  = tp_item_reg;
    assign cl_keep[0]  = 1'b1;
    assign cl_te[0]    = '0;
    assign cl_tl[0]    = P_ONE;
    assign cl_t[0]     = t_reg;
    assign cl_flags[0] = flags_reg;

    for (genvar g = 0; g < NT; g++)
    begin : g_clip
        lcci_clip_cell #(
            .PF(PARAM_FRAC_BITS)
        ) u_clip (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (cl_valid[g]),
            .in_item  (cl_item[g]),
            .in_keep  (cl_keep[g]),
            .in_te    (cl_te[g]),
            .in_tl    (cl_tl[g]),
            .in_t     (cl_t[g]),
            .in_flags (cl_flags[g]),
            .out_valid(cl_valid[g+1]),
            .out_item (cl_item[g+1]),
            .out_keep (cl_keep[g+1]),
            .out_te   (cl_te[g+1]),
            .out_tl   (cl_tl[g+1]),
            .out_t    (cl_t[g+1]),
            .out_flags(cl_flags[g+1])
        );
    end

    // Interpolation and output register.
    lcci_interp #(
        .PF(PARAM_FRAC_BITS)
    ) u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cl_valid[NT]),
        .in_item   (cl_item[NT]),
        .in_keep   (cl_keep[NT]),
        .in_te     (cl_te[NT]),
        .in_tl     (cl_tl[NT]),
        .out_valid (m_tvalid),
        .out_result(result)
    );

    // The visible flag travels beside the clipped segment.
    assign m_tdata = result[lcci_pkg::OUT_W:1];
    assign m_tuser = result.visible;

endmodule

// ===== rtl/lcci_div_cell.sv =====
// One restoring division step for all six boundary tests of a segment.
// Depends on lcci_pkg; chained by line_clip_color_interp.
module lcci_div_cell #(
    parameter int QW = 17
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              en,
    input  logic                                              in_valid,
    input  lcci_pkg::lcci_item_t                              in_item,
    input  lcci_pkg::lcci_lane_t [lcci_pkg::NUM_TESTS-1:0]    in_lane,
    input  logic [lcci_pkg::NUM_TESTS-1:0][QW-1:0]            in_q,
    output logic                                              out_valid,
    output lcci_pkg::lcci_item_t                              out_item,
    output lcci_pkg::lcci_lane_t [lcci_pkg::NUM_TESTS-1:0]    out_lane,
    output logic [lcci_pkg::NUM_TESTS-1:0][QW-1:0]            out_q
);

    logic                                           valid_reg;
    lcci_pkg::lcci_item_t                           item_reg;
    lcci_pkg::lcci_lane_t [lcci_pkg::NUM_TESTS-1:0] lane_reg;
    lcci_pkg::lcci_lane_t [lcci_pkg::NUM_TESTS-1:0] lane_next;
    logic [lcci_pkg::NUM_TESTS-1:0][QW-1:0]         q_reg;
    logic [lcci_pkg::NUM_TESTS-1:0][QW-1:0]         q_next;
    logic [lcci_pkg::NUM_TESTS-1:0]                 ge;
    logic [lcci_pkg::NUM_TESTS-1:0][lcci_pkg::REM_W-1:0] rem_sub;

    // Compare, subtract when it fits, then shift the remainder for the next bit.
    always_comb
    begin
        for (int k = 0; k < lcci_pkg::NUM_TESTS; k++)
        begin
            ge[k]            = in_lane[k].rem >= in_lane[k].dvs;
            rem_sub[k]       = ge[k] ? (in_lane[k].rem - in_lane[k].dvs) : in_lane[k].rem;
            lane_next[k]     = in_lane[k];
            lane_next[k].rem = {rem_sub[k][lcci_pkg::REM_W-2:0], 1'b0};
            q_next[k]        = {in_q[k][QW-2:0], ge[k]};
        end
    end

    // Stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= in_item;
            lane_reg <= lane_next;
            q_reg    <= q_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_lane  = lane_reg;
    assign out_q     = q_reg;

endmodule

// ===== rtl/lcci_clip_cell.sv =====
// Applies the oldest pending boundary test to the entry and exit parameters.
// Depends on lcci_pkg; six of these are chained by line_clip_color_interp.
module lcci_clip_cell #(
    parameter int PF = 16
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           en,
    input  logic                                           in_valid,
    input  lcci_pkg::lcci_item_t                           in_item,
    input  logic                                           in_keep,
    input  logic [PF:0]                                    in_te,
    input  logic [PF:0]                                    in_tl,
    input  logic [lcci_pkg::NUM_TESTS-1:0][PF+1:0]         in_t,
    input  lcci_pkg::lcci_flags_t [lcci_pkg::NUM_TESTS-1:0] in_flags,
    output logic                                           out_valid,
    output lcci_pkg::lcci_item_t                           out_item,
    output logic                                           out_keep,
    output logic [PF:0]                                    out_te,
    output logic [PF:0]                                    out_tl,
    output logic [lcci_pkg::NUM_TESTS-1:0][PF+1:0]         out_t,
    output lcci_pkg::lcci_flags_t [lcci_pkg::NUM_TESTS-1:0] out_flags
);

    localparam int TW = PF + 2;

    logic                                            valid_reg;
    lcci_pkg::lcci_item_t                            item_reg;
    logic                                            keep_reg;
    logic                                            keep_next;
    logic [PF:0]                                     te_reg;
    logic [PF:0]                                     te_next;
    logic [PF:0]                                     tl_reg;
    logic [PF:0]                                     tl_next;
    logic [lcci_pkg::NUM_TESTS-1:0][TW-1:0]          t_reg;
    lcci_pkg::lcci_flags_t [lcci_pkg::NUM_TESTS-1:0] flags_reg;
    logic signed [TW-1:0]                            t0;
    logic signed [TW-1:0]                            te_s;
    logic signed [TW-1:0]                            tl_s;
    lcci_pkg::lcci_flags_t                           f0;

    // Entering edges raise the entry parameter, leaving edges lower the exit one.
    always_comb
    begin
        t0        = $signed(in_t[0]);
        te_s      = $signed({1'b0, in_te});
        tl_s      = $signed({1'b0, in_tl});
        f0        = in_flags[0];
        keep_next = in_keep;
        te_next   = in_te;
        tl_next   = in_tl;
        if (in_keep)
        begin
            if (f0.dpos)
            begin
                if (t0 > tl_s)
                begin
                    keep_next = 1'b0;
                end
                else if (t0 > te_s)
                begin
                    te_next = t0[PF:0];
                end
            end
            else if (!f0.dzero)
            begin
                if (t0 < te_s)
                begin
                    keep_next = 1'b0;
                end
                else if (t0 < tl_s)
                begin
                    tl_next = t0[PF:0];
                end
            end
            else if (f0.npos)
            begin
                keep_next = 1'b0;
            end
        end
    end

    // Stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload; the pending tests move down one place.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg  <= in_item;
            keep_reg  <= keep_next;
            te_reg    <= te_next;
            tl_reg    <= tl_next;
            t_reg     <= in_t >> TW;
            flags_reg <= in_flags >> $bits(lcci_pkg::lcci_flags_t);
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_keep  = keep_reg;
    assign out_te    = te_reg;
    assign out_tl    = tl_reg;
    assign out_t     = t_reg;
    assign out_flags = flags_reg;

endmodule

// ===== rtl/lcci_interp.sv =====
// Moves the endpoints and colors to the clip parameters, and holds the result.
// Depends on lcci_pkg; instantiated by line_clip_color_interp.
module lcci_interp #(
    parameter int PF = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  lcci_pkg::lcci_item_t   in_item,
    input  logic                   in_keep,
    input  logic [PF:0]            in_te,
    input  logic [PF:0]            in_tl,
    output logic                   out_valid,
    output lcci_pkg::lcci_result_t out_result
);

    localparam int PPW = lcci_pkg::DIFF_W + PF + 2;
    localparam int CPW = lcci_pkg::CHAN_W + PF + 3;
    localparam logic signed [PPW-1:0] PBIAS = PPW'((64'd1 << PF) - 64'd1);
    localparam logic signed [CPW-1:0] CBIAS = CPW'((64'd1 << PF) - 64'd1);

    logic signed [lcci_pkg::COORD_W-1:0] s_arr [lcci_pkg::NUM_AXES];
    logic signed [lcci_pkg::COORD_W-1:0] e_arr [lcci_pkg::NUM_AXES];
    logic signed [PPW-1:0]               d_ext [lcci_pkg::NUM_AXES];
    logic signed [CPW-1:0]               cd_ext [lcci_pkg::NUM_CHAN];
    logic signed [PPW-1:0]               te_p;
    logic signed [PPW-1:0]               tl_p;
    logic signed [CPW-1:0]               te_c;
    logic signed [CPW-1:0]               tl_c;

    logic signed [PPW-1:0] pe_next [lcci_pkg::NUM_AXES];
    logic signed [PPW-1:0] pl_next [lcci_pkg::NUM_AXES];
    logic signed [CPW-1:0] ce_next [lcci_pkg::NUM_CHAN];
    logic signed [CPW-1:0] cl_next [lcci_pkg::NUM_CHAN];
    logic signed [PPW-1:0] pe_reg  [lcci_pkg::NUM_AXES];
    logic signed [PPW-1:0] pl_reg  [lcci_pkg::NUM_AXES];
    logic signed [CPW-1:0] ce_reg  [lcci_pkg::NUM_CHAN];
    logic signed [CPW-1:0] cl_reg  [lcci_pkg::NUM_CHAN];
    logic                  mul_valid_reg;
    lcci_pkg::lcci_item_t  mul_item_reg;
    logic                  mul_keep_reg;

    logic signed [lcci_pkg::COORD_W-1:0] ms_arr [lcci_pkg::NUM_AXES];
    logic signed [PPW-1:0]               pe_sh  [lcci_pkg::NUM_AXES];
    logic signed [PPW-1:0]               pl_sh  [lcci_pkg::NUM_AXES];
    logic signed [CPW-1:0]               ce_sh  [lcci_pkg::NUM_CHAN];
    logic signed [CPW-1:0]               cl_sh  [lcci_pkg::NUM_CHAN];
    logic [lcci_pkg::EXT_W-1:0]          ve_sum [lcci_pkg::NUM_AXES];
    logic [lcci_pkg::EXT_W-1:0]          vl_sum [lcci_pkg::NUM_AXES];
    logic [lcci_pkg::CHAN_W+1:0]         ce_sum [lcci_pkg::NUM_CHAN];
    logic [lcci_pkg::CHAN_W+1:0]         cl_sum [lcci_pkg::NUM_CHAN];
    logic [lcci_pkg::COLOR_W-1:0]        col_e;
    logic [lcci_pkg::COLOR_W-1:0]        col_l;
    lcci_pkg::lcci_result_t              result_next;
    lcci_pkg::lcci_result_t              result_reg;
    logic                                out_valid_reg;

    // Differences times the two parameters.
    always_comb
    begin
        s_arr[0] = in_item.start_x;
        s_arr[1] = in_item.start_y;
        s_arr[2] = in_item.start_z;
        e_arr[0] = in_item.end_x;
        e_arr[1] = in_item.end_y;
        e_arr[2] = in_item.end_z;
        te_p     = $signed(PPW'(in_te));
        tl_p     = $signed(PPW'(in_tl));
        te_c     = $signed(CPW'(in_te));
        tl_c     = $signed(CPW'(in_tl));
        for (int a = 0; a < lcci_pkg::NUM_AXES; a++)
        begin
            d_ext[a]   = PPW'(e_arr[a]) - PPW'(s_arr[a]);
            pe_next[a] = d_ext[a] * te_p;
            pl_next[a] = d_ext[a] * tl_p;
        end
        for (int c = 0; c < lcci_pkg::NUM_CHAN; c++)
        begin
            cd_ext[c]  = $signed(CPW'(in_item.end_color[c*lcci_pkg::CHAN_W +: lcci_pkg::CHAN_W]))
                       - $signed(CPW'(in_item.start_color[c*lcci_pkg::CHAN_W +: lcci_pkg::CHAN_W]));
            ce_next[c] = cd_ext[c] * te_c;
            cl_next[c] = cd_ext[c] * tl_c;
        end
    end

    // Product stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_item_reg <= in_item;
            mul_keep_reg <= in_keep;
            pe_reg       <= pe_next;
            pl_reg       <= pl_next;
            ce_reg       <= ce_next;
            cl_reg       <= cl_next;
        end
    end

    // Scale the products back, rounding toward zero, and add the start values.
    always_comb
    begin
        ms_arr[0] = mul_item_reg.start_x;
        ms_arr[1] = mul_item_reg.start_y;
        ms_arr[2] = mul_item_reg.start_z;
        for (int a = 0; a < lcci_pkg::NUM_AXES; a++)
        begin
            pe_sh[a]  = (pe_reg[a] + (pe_reg[a][PPW-1] ? PBIAS : '0)) >>> PF;
            pl_sh[a]  = (pl_reg[a] + (pl_reg[a][PPW-1] ? PBIAS : '0)) >>> PF;
            ve_sum[a] = lcci_pkg::EXT_W'(ms_arr[a]) + pe_sh[a][lcci_pkg::EXT_W-1:0];
            vl_sum[a] = lcci_pkg::EXT_W'(ms_arr[a]) + pl_sh[a][lcci_pkg::EXT_W-1:0];
        end
        col_e = '0;
        col_l = '0;
        for (int c = 0; c < lcci_pkg::NUM_CHAN; c++)
        begin
            ce_sh[c]  = (ce_reg[c] + (ce_reg[c][CPW-1] ? CBIAS : '0)) >>> PF;
            cl_sh[c]  = (cl_reg[c] + (cl_reg[c][CPW-1] ? CBIAS : '0)) >>> PF;
            ce_sum[c] = {2'b00, mul_item_reg.start_color[c*lcci_pkg::CHAN_W +: lcci_pkg::CHAN_W]}
                      + ce_sh[c][lcci_pkg::CHAN_W+1:0];
            cl_sum[c] = {2'b00, mul_item_reg.start_color[c*lcci_pkg::CHAN_W +: lcci_pkg::CHAN_W]}
                      + cl_sh[c][lcci_pkg::CHAN_W+1:0];
            col_e[c*lcci_pkg::CHAN_W +: lcci_pkg::CHAN_W] = ce_sum[c][lcci_pkg::CHAN_W-1:0];
            col_l[c*lcci_pkg::CHAN_W +: lcci_pkg::CHAN_W] = cl_sum[c][lcci_pkg::CHAN_W-1:0];
        end

        // A rejected segment passes through unchanged.
        result_next         = '0;
        result_next.visible = mul_keep_reg;
        if (mul_keep_reg)
        begin
            result_next.out_start_x     = ve_sum[0][lcci_pkg::COORD_W-1:0];
            result_next.out_start_y     = ve_sum[1][lcci_pkg::COORD_W-1:0];
            result_next.out_start_z     = ve_sum[2][lcci_pkg::COORD_W-1:0];
            result_next.out_end_x       = vl_sum[0][lcci_pkg::COORD_W-1:0];
            result_next.out_end_y       = vl_sum[1][lcci_pkg::COORD_W-1:0];
            result_next.out_end_z       = vl_sum[2][lcci_pkg::COORD_W-1:0];
            result_next.out_start_color = col_e;
            result_next.out_end_color   = col_l;
        end
        else
        begin
            result_next.out_start_x     = mul_item_reg.start_x;
            result_next.out_start_y     = mul_item_reg.start_y;
            result_next.out_start_z     = mul_item_reg.start_z;
            result_next.out_end_x       = mul_item_reg.end_x;
            result_next.out_end_y       = mul_item_reg.end_y;
            result_next.out_end_z       = mul_item_reg.end_z;
            result_next.out_start_color = mul_item_reg.start_color;
            result_next.out_end_color   = mul_item_reg.end_color;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

endmodule
